FILE: rtl/placement_density_metrics_assert.svh
// ----------------------------------------------------------------------------
// placement density metrics assertion macros
// concurrent checks on clk, disabled while rst is high; empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PLACEMENT_DENSITY_METRICS_ASSERT_SVH
`define PLACEMENT_DENSITY_METRICS_ASSERT_SVH
`ifndef SYNTHESIS
`define PDM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDM_ASSERT_IMPLY(label, ante, cons, msg)
`define PDM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg
// widths, codes and word types shared by the placement density metrics block
// ----------------------------------------------------------------------------
package pdm_pkg;

  localparam int FIELD_W   = 32;              // input fields, two's complement
  localparam int MAG_W     = FIELD_W - 1;     // magnitude of a clamped field
  localparam int SQ_W      = 2 * MAG_W;       // squared overflow
  localparam int AREA_W    = 47;              // Q39.8 area totals
  localparam int PEN_W     = 63;              // Q47.16 penalty
  localparam int UACC_W    = 48;              // utilisation sum
  localparam int CNT_W     = 17;              // bin counters
  localparam int RATIO_W   = 32;              // Q16.16 ratios
  localparam int STATUS_W  = 2;
  localparam int FRAC_W    = 16;              // extra fraction bits for the ratio
  localparam int DIVIDEND_W = AREA_W + FRAC_W;
  localparam int DIVISOR_W  = AREA_W;

  localparam int unsigned DEF_MAX_BINS = 65536;

  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INF = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd3;

  localparam logic DIV_SEL_MEAN  = 1'b0;
  localparam logic DIV_SEL_RATIO = 1'b1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] mov_area;
    logic signed [FIELD_W-1:0] fix_area;
    logic signed [FIELD_W-1:0] mov_cap;
    logic signed [FIELD_W-1:0] overflow_area;
    logic signed [FIELD_W-1:0] utilization;
    logic                      utilization_infinite;
    logic                      last_bin;
  } pdm_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AREA_W-1:0]   total_movable;
    logic [AREA_W-1:0]   total_fixed;
    logic [AREA_W-1:0]   total_capacity;
    logic [AREA_W-1:0]   ovf_total;
    logic [PEN_W-1:0]    density_penalty;
    logic [CNT_W-1:0]    overflow_bins;
    logic [CNT_W-1:0]    zero_capacity_bins;
    logic [CNT_W-1:0]    occupied_zero_capacity_bins;
    logic [RATIO_W-1:0]  mean_utilization;
    logic [RATIO_W-1:0]  peak_utilization;
    logic [RATIO_W-1:0]  ovf_ratio;
  } pdm_out_t;

  typedef struct packed {
    logic load;        // capture an accepted word into the input stage
    logic accumulate;  // fold the input stage into the totals
    logic zero_quot;   // clear mean and ratio before the divisions
    logic div_start;
    logic div_sel;
    logic take_mean;
    logic take_ratio;
    logic emit;        // load the result register and clear the totals
  } pdm_cmd_t;

  typedef struct packed {
    logic usable_nz;
    logic movable_nz;
    logic div_busy;
    logic div_done;
  } pdm_stat_t;

endpackage

FILE: rtl/pdm_divider.sv
// ----------------------------------------------------------------------------
// pdm_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdm_divider import pdm_pkg::*; #(
  parameter int DIVIDEND_BITS = DIVIDEND_W,
  parameter int DIVISOR_BITS  = DIVISOR_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [STEP_W-1:0]        steps;

  logic [DIVISOR_BITS:0]    rem_shift;
  logic [DIVISOR_BITS:0]    rem_sub;
  logic                     ge;
  logic [DIVISOR_BITS-1:0]  rem_next;

  assign rem_shift = {rem, quo[DIVIDEND_BITS-1]};
  assign ge        = rem_shift >= {1'b0, dvs};
  assign rem_sub   = rem_shift - {1'b0, dvs};
  // the partial remainder always stays below a nonzero divisor
  assign rem_next  = ge ? rem_sub[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_BITS);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVIDEND_BITS-2:0], ge};
    end
  end

endmodule

FILE: rtl/pdm_datapath.sv
// ----------------------------------------------------------------------------
// pdm_datapath
// input stage with overflow square, saturating totals, counters, peak,
// error latch, shared divider and result register
// ----------------------------------------------------------------------------
module pdm_datapath import pdm_pkg::*; #(
  parameter int unsigned MAX_BINS = DEF_MAX_BINS
) (
  input  logic      clk,
  input  logic      rst,
  input  pdm_in_t   in_word,
  input  pdm_cmd_t  cmd,
  output pdm_stat_t stat,
  output pdm_out_t  out_word
);

  localparam int unsigned CntMax    = (1 << CNT_W) - 1;
  localparam int unsigned CntLimInt = (MAX_BINS > CntMax) ? CntMax : MAX_BINS;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CntLimInt);

  function automatic logic [MAG_W-1:0] clamp_field(input logic [FIELD_W-1:0] v);
    return v[FIELD_W-1] ? '0 : v[MAG_W-1:0];
  endfunction

  function automatic logic [RATIO_W-1:0] sat_ratio(input logic [DIVIDEND_W-1:0] q);
    return (q[DIVIDEND_W-1:RATIO_W] != '0) ? '1 : q[RATIO_W-1:0];
  endfunction

  // input stage
  logic [MAG_W-1:0]   mov_c, fix_c, cap_c, ovf_c, util_c;
  logic               neg_c, bad_inf_c;
  logic [RATIO_W-1:0] peak_c;
  logic [SQ_W-1:0]    sq_c;

  logic [MAG_W-1:0]   s1_mov, s1_fix, s1_cap, s1_ovf, s1_util;
  logic [SQ_W-1:0]    s1_sq;
  logic               s1_neg, s1_bad_inf;
  logic [RATIO_W-1:0] s1_peak;

  assign mov_c  = clamp_field(in_word.mov_area);
  assign fix_c  = clamp_field(in_word.fix_area);
  assign cap_c  = clamp_field(in_word.mov_cap);
  assign ovf_c  = clamp_field(in_word.overflow_area);
  assign util_c = clamp_field(in_word.utilization);
  assign neg_c  = in_word.mov_area[FIELD_W-1] | in_word.fix_area[FIELD_W-1]
                | in_word.mov_cap[FIELD_W-1] | in_word.overflow_area[FIELD_W-1]
                | in_word.utilization[FIELD_W-1];
  // infinity only makes sense on an occupied zero-capacity bin
  assign bad_inf_c = in_word.utilization_infinite & ~(cap_c == '0 && mov_c != '0);
  assign peak_c    = (in_word.utilization_infinite & ~bad_inf_c) ? '1
                                                                : RATIO_W'(util_c);
  assign sq_c      = SQ_W'(ovf_c) * SQ_W'(ovf_c);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1_mov     <= mov_c;
      s1_fix     <= fix_c;
      s1_cap     <= cap_c;
      s1_ovf     <= ovf_c;
      s1_util    <= util_c;
      s1_sq      <= sq_c;
      s1_neg     <= neg_c;
      s1_bad_inf <= bad_inf_c;
      s1_peak    <= peak_c;
    end
  end

  // totals
  logic [AREA_W-1:0]   acc_movable, acc_fixed, acc_capacity, acc_overflow;
  logic [PEN_W-1:0]    acc_penalty;
  logic [UACC_W-1:0]   acc_utilization;
  logic [CNT_W-1:0]    cnt_overflow, cnt_zero_capacity, cnt_zero_occupied, cnt_usable;
  logic [RATIO_W-1:0]  max_seen;
  logic [STATUS_W-1:0] error_code;

  logic [AREA_W:0]     sum_mov, sum_fix, sum_cap, sum_ovf;
  logic [PEN_W:0]      sum_pen;
  logic [UACC_W:0]     sum_util;
  logic                cap_zero, mov_pos, ovf_pos;
  logic                ovf_full, zc_full, zo_full, us_full;
  logic                sat;

  assign sum_mov  = {1'b0, acc_movable}  + (AREA_W+1)'(s1_mov);
  assign sum_fix  = {1'b0, acc_fixed}    + (AREA_W+1)'(s1_fix);
  assign sum_cap  = {1'b0, acc_capacity} + (AREA_W+1)'(s1_cap);
  assign sum_ovf  = {1'b0, acc_overflow} + (AREA_W+1)'(s1_ovf);
  assign sum_pen  = {1'b0, acc_penalty}  + (PEN_W+1)'(s1_sq);
  assign sum_util = {1'b0, acc_utilization} + (UACC_W+1)'(s1_util);

  assign cap_zero = (s1_cap == '0);
  assign mov_pos  = (s1_mov != '0);
  assign ovf_pos  = (s1_ovf != '0);
  assign ovf_full = (cnt_overflow == CNT_LIMIT);
  assign zc_full  = (cnt_zero_capacity == CNT_LIMIT);
  assign zo_full  = (cnt_zero_occupied == CNT_LIMIT);
  assign us_full  = (cnt_usable == CNT_LIMIT);

  assign sat = sum_mov[AREA_W] | sum_fix[AREA_W] | sum_cap[AREA_W] | sum_ovf[AREA_W]
             | sum_pen[PEN_W]
             | (ovf_pos & ovf_full)
             | (cap_zero & zc_full)
             | (cap_zero & mov_pos & zo_full)
             | (~cap_zero & (sum_util[UACC_W] | us_full));

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      acc_movable       <= '0;
      acc_fixed         <= '0;
      acc_capacity      <= '0;
      acc_overflow      <= '0;
      acc_penalty       <= '0;
      acc_utilization   <= '0;
      cnt_overflow      <= '0;
      cnt_zero_capacity <= '0;
      cnt_zero_occupied <= '0;
      cnt_usable        <= '0;
      max_seen          <= '0;
      error_code        <= STATUS_OK;
    end else if (cmd.accumulate) begin
      acc_movable  <= sum_mov[AREA_W] ? '1 : sum_mov[AREA_W-1:0];
      acc_fixed    <= sum_fix[AREA_W] ? '1 : sum_fix[AREA_W-1:0];
      acc_capacity <= sum_cap[AREA_W] ? '1 : sum_cap[AREA_W-1:0];
      acc_overflow <= sum_ovf[AREA_W] ? '1 : sum_ovf[AREA_W-1:0];
      acc_penalty  <= sum_pen[PEN_W]  ? '1 : sum_pen[PEN_W-1:0];
      if (ovf_pos && !ovf_full) begin
        cnt_overflow <= cnt_overflow + CNT_W'(1);
      end
      if (cap_zero) begin
        if (!zc_full) begin
          cnt_zero_capacity <= cnt_zero_capacity + CNT_W'(1);
        end
        if (mov_pos && !zo_full) begin
          cnt_zero_occupied <= cnt_zero_occupied + CNT_W'(1);
        end
      end else begin
        acc_utilization <= sum_util[UACC_W] ? '1 : sum_util[UACC_W-1:0];
        if (!us_full) begin
          cnt_usable <= cnt_usable + CNT_W'(1);
        end
      end
      if (s1_peak > max_seen) begin
        max_seen <= s1_peak;
      end
      // first fault of the grid sticks
      if (error_code == STATUS_OK) begin
        if (s1_neg) begin
          error_code <= STATUS_NEG;
        end else if (s1_bad_inf) begin
          error_code <= STATUS_INF;
        end else if (sat) begin
          error_code <= STATUS_SAT;
        end
      end
    end
  end

  // shared divider for mean and ratio
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic                  div_busy, div_done;

  always_comb begin
    if (cmd.div_sel == DIV_SEL_RATIO) begin
      div_dividend = {acc_overflow, {FRAC_W{1'b0}}};
      div_divisor  = acc_movable;
    end else begin
      div_dividend = DIVIDEND_W'(acc_utilization);
      div_divisor  = DIVISOR_W'(cnt_usable);
    end
  end

  pdm_divider #(
    .DIVIDEND_BITS (DIVIDEND_W),
    .DIVISOR_BITS  (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  logic [RATIO_W-1:0] mean_q, ratio_q;

  always_ff @(posedge clk) begin
    if (cmd.zero_quot) begin
      mean_q  <= '0;
      ratio_q <= '0;
    end else begin
      if (cmd.take_mean) begin
        mean_q <= sat_ratio(div_quotient);
      end
      if (cmd.take_ratio) begin
        ratio_q <= sat_ratio(div_quotient);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.status                      <= error_code;
      out_word.total_movable               <= acc_movable;
      out_word.total_fixed                 <= acc_fixed;
      out_word.total_capacity              <= acc_capacity;
      out_word.ovf_total                   <= acc_overflow;
      out_word.density_penalty             <= acc_penalty;
      out_word.overflow_bins               <= cnt_overflow;
      out_word.zero_capacity_bins          <= cnt_zero_capacity;
      out_word.occupied_zero_capacity_bins <= cnt_zero_occupied;
      out_word.mean_utilization            <= mean_q;
      out_word.peak_utilization            <= max_seen;
      out_word.ovf_ratio                   <= ratio_q;
    end
  end

  assign stat.usable_nz  = (cnt_usable != '0);
  assign stat.movable_nz = (acc_movable != '0);
  assign stat.div_busy   = div_busy;
  assign stat.div_done   = div_done;

endmodule

FILE: rtl/pdm_ctrl.sv
// ----------------------------------------------------------------------------
// pdm_ctrl
// sequences accumulation, the two divisions and the result hand-off
// ----------------------------------------------------------------------------
module pdm_ctrl import pdm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last_bin,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pdm_stat_t stat,
  output pdm_cmd_t  cmd
);

  localparam logic [2:0] S_RUN        = 3'd0;
  localparam logic [2:0] S_FLUSH      = 3'd1;
  localparam logic [2:0] S_MEAN_GO    = 3'd2;
  localparam logic [2:0] S_MEAN_WAIT  = 3'd3;
  localparam logic [2:0] S_RATIO_GO   = 3'd4;
  localparam logic [2:0] S_RATIO_WAIT = 3'd5;
  localparam logic [2:0] S_EMIT       = 3'd6;

  logic [2:0] state, state_next;
  logic       pend;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_RUN);
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.load       = accept;
    cmd.accumulate = pend;
    cmd.div_sel    = DIV_SEL_MEAN;
    case (state)
      S_RUN: begin
        if (accept && last_bin) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // the last word is folded in this cycle
        cmd.zero_quot = 1'b1;
        state_next    = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        if (stat.usable_nz) begin
          cmd.div_start = 1'b1;
          state_next    = S_MEAN_WAIT;
        end else begin
          state_next = S_RATIO_GO;
        end
      end
      S_MEAN_WAIT: begin
        if (stat.div_done) begin
          cmd.take_mean = 1'b1;
          state_next    = S_RATIO_GO;
        end
      end
      S_RATIO_GO: begin
        cmd.div_sel = DIV_SEL_RATIO;
        if (stat.movable_nz) begin
          cmd.div_start = 1'b1;
          state_next    = S_RATIO_WAIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RATIO_WAIT: begin
        if (stat.div_done) begin
          cmd.take_ratio = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= accept;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/placement_density_metrics.sv
// ----------------------------------------------------------------------------
// placement_density_metrics
// streaming bin density evaluator with one summary word per grid
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+-----------
//   in      | in        | in_valid / in_stall  | pdm_in_t
//   out     | out       | out_valid / out_stall| pdm_out_t
//
// bins are taken one per cycle while in_stall is low; each passes an
// input stage (overflow square), then folds into the saturating totals
// the next cycle. after the last bin, input stalls through flush, set-up,
// both divisions on the shared 63-step divider, and emit; a division
// with a zero divisor is skipped.
// synchronous reset clears the totals at once; there is no clearing pass.
// while out_stall still holds an earlier result, the next one waits to be
// loaded and input stays stalled until it is.
// ----------------------------------------------------------------------------
`include "placement_density_metrics_assert.svh"

module placement_density_metrics import pdm_pkg::*; #(
  parameter int unsigned MAX_BINS = DEF_MAX_BINS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  pdm_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output pdm_out_t out_word
);

  pdm_cmd_t  cmd;
  pdm_stat_t stat;

  pdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_bin  (in_word.last_bin),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdm_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

  `PDM_ASSERT_IMPLY(a_no_load_in_div, cmd.load, !stat.div_busy, "word taken during division")
  `PDM_ASSERT_IMPLY(a_start_when_idle, cmd.div_start, !stat.div_busy, "divider restarted early")
  `PDM_ASSERT_IMPLY(a_emit_free, cmd.emit, (!out_valid || !out_stall), "result overwritten")
  `PDM_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid, "emitted result not offered")

endmodule
